// ----- design/assert_macros.svh -----
// assertion helpers for the tokenizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define RFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, held off while reset is low
`define RFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ----- design/rft_pkg.sv -----
package rft_pkg;

  // characters that steer the tokenizer
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // configuration register indexes
  localparam logic [1:0] CFG_BUFFER_PRESENT = 2'd0;
  localparam logic [1:0] CFG_PRESET_TEXT    = 2'd1;
  localparam logic [1:0] CFG_BUFFER_SPACE   = 2'd2;

  typedef enum logic [2:0] {
    ST_CONTINUE = 3'd0,
    ST_COMMA    = 3'd1,
    ST_PAREN    = 3'd2,
    ST_CR       = 3'd3,
    ST_ERROR    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INT  = 2'd1,
    KIND_TEXT = 2'd2
  } kind_t;

  typedef struct packed {
    logic       buffer_present;
    logic       preset_text;
    logic [7:0] buffer_space;
  } cfg_t;

  typedef struct packed {
    logic               store_valid;
    logic [7:0]         store_byte;
    logic [7:0]         store_index;
    status_t            status;
    kind_t              kind;
    logic signed [31:0] value;
  } result_t;

endpackage

// ----- design/rft_cfg_regs.sv -----
module rft_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output rft_pkg::cfg_t     cfg
);

  rft_pkg::cfg_t cfg_r;

  // register write decode, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rft_pkg::CFG_BUFFER_PRESENT: cfg_r.buffer_present <= cfg_wdata[0];
        rft_pkg::CFG_PRESET_TEXT:    cfg_r.preset_text    <= cfg_wdata[0];
        rft_pkg::CFG_BUFFER_SPACE:   cfg_r.buffer_space   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/rft_core.sv -----
module rft_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        char_in,
  input  rft_pkg::cfg_t     cfg,
  output rft_pkg::result_t  res
);

  logic               in_quotes_r, in_quotes_nxt;
  logic               in_parens_r, in_parens_nxt;
  logic               started_r, started_nxt;
  logic               raw_mode_r, raw_mode_nxt;
  logic [7:0]         space_r, space_nxt;
  logic [7:0]         wpos_r, wpos_nxt;
  logic               digits_r, digits_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        acc_r, acc_nxt;
  rft_pkg::kind_t     kind_r, kind_nxt;

  logic               is_digit;
  logic [31:0]        digit_ext;
  logic [31:0]        acc_x10;
  logic [31:0]        acc_mac;
  logic               clear_f;
  logic               unquoted;

  // accumulator holds the signed value, so a minus sign subtracts each digit
  assign is_digit  = (char_in >= rft_pkg::CH_ZERO) && (char_in <= rft_pkg::CH_NINE);
  assign digit_ext = {28'd0, char_in[3:0]};
  assign acc_x10   = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};
  assign acc_mac   = neg_r ? (acc_x10 - digit_ext) : (acc_x10 + digit_ext);
  assign unquoted  = !in_quotes_r;

  // per-character decision
  always_comb begin
    in_quotes_nxt = in_quotes_r;
    in_parens_nxt = in_parens_r;
    started_nxt   = started_r;
    raw_mode_nxt  = raw_mode_r;
    space_nxt     = space_r;
    wpos_nxt      = wpos_r;
    digits_nxt    = digits_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    kind_nxt      = kind_r;
    clear_f       = 1'b0;
    res           = '0;
    res.status    = rft_pkg::ST_CONTINUE;

    // running integer, frozen by the first non-digit
    if (digits_r) begin
      if (is_digit) begin
        acc_nxt = acc_mac;
      end else begin
        digits_nxt = 1'b0;
      end
    end

    priority if (char_in == rft_pkg::CH_NUL) begin
      res.status = rft_pkg::ST_ERROR;
      clear_f    = 1'b1;
    end else if (char_in == rft_pkg::CH_CR) begin
      if (raw_mode_r) begin
        if (space_r != 8'd0) begin
          res.store_valid = 1'b1;
          res.store_index = wpos_r;
        end
        res.status = rft_pkg::ST_CR;
        clear_f    = 1'b1;
      end else if (unquoted) begin
        res.status = rft_pkg::ST_ERROR;
        clear_f    = 1'b1;
      end
    end else if ((char_in == rft_pkg::CH_COMMA || char_in == rft_pkg::CH_RPAREN)
                 && unquoted && !in_parens_r) begin
      // field end, terminator for a live raw capture
      if (raw_mode_r && space_r != 8'd0) begin
        res.store_valid = 1'b1;
        res.store_index = wpos_r;
      end
      res.status = (char_in == rft_pkg::CH_COMMA) ? rft_pkg::ST_COMMA : rft_pkg::ST_PAREN;
      clear_f    = 1'b1;
    end else if (char_in == rft_pkg::CH_QUOTE) begin
      if (in_quotes_r) begin
        if (started_r && space_r != 8'd0) begin
          res.store_valid = 1'b1;
          res.store_index = wpos_r;
        end
        space_nxt     = 8'd0;
        in_quotes_nxt = 1'b0;
        started_nxt   = 1'b0;
      end else begin
        in_quotes_nxt = 1'b1;
      end
    end else begin
      // first character of a field picks its kind
      if (!started_r) begin
        started_nxt = 1'b1;
        digits_nxt  = 1'b0;
        if (in_quotes_r) begin
          kind_nxt  = rft_pkg::KIND_TEXT;
          space_nxt = cfg.buffer_present ? cfg.buffer_space : 8'd0;
          wpos_nxt  = 8'd0;
        end else if (cfg.buffer_present && cfg.preset_text) begin
          raw_mode_nxt = 1'b1;
          kind_nxt     = rft_pkg::KIND_TEXT;
          space_nxt    = cfg.buffer_space;
          wpos_nxt     = 8'd0;
        end else if (is_digit || char_in == rft_pkg::CH_MINUS) begin
          kind_nxt   = rft_pkg::KIND_INT;
          digits_nxt = 1'b1;
          neg_nxt    = (char_in == rft_pkg::CH_MINUS);
          acc_nxt    = is_digit ? digit_ext : 32'd0;
        end else if (cfg.buffer_present) begin
          raw_mode_nxt = 1'b1;
          kind_nxt     = rft_pkg::KIND_TEXT;
          space_nxt    = cfg.buffer_space;
          wpos_nxt     = 8'd0;
        end
      end

      // one level of parentheses
      if (char_in == rft_pkg::CH_LPAREN && unquoted && !in_parens_r) begin
        in_parens_nxt = 1'b1;
      end else if (char_in == rft_pkg::CH_RPAREN && unquoted && in_parens_r) begin
        in_parens_nxt = 1'b0;
      end

      // capture the byte while space remains
      if ((in_quotes_r || raw_mode_nxt) && space_nxt != 8'd0) begin
        res.store_valid = 1'b1;
        res.store_byte  = char_in;
        res.store_index = wpos_nxt;
        wpos_nxt        = wpos_nxt + 8'd1;
        space_nxt       = space_nxt - 8'd1;
      end
    end

    // report uses the field as it stands before any clear
    res.kind  = kind_nxt;
    res.value = (kind_nxt == rft_pkg::KIND_INT) ? acc_nxt : 32'sd0;

    if (clear_f) begin
      in_quotes_nxt = 1'b0;
      in_parens_nxt = 1'b0;
      started_nxt   = 1'b0;
      raw_mode_nxt  = 1'b0;
      space_nxt     = 8'd0;
      wpos_nxt      = 8'd0;
      digits_nxt    = 1'b0;
      neg_nxt       = 1'b0;
      acc_nxt       = 32'd0;
      kind_nxt      = rft_pkg::KIND_NONE;
    end
  end

  // field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      in_parens_r <= 1'b0;
      started_r   <= 1'b0;
      raw_mode_r  <= 1'b0;
      space_r     <= 8'd0;
      wpos_r      <= 8'd0;
      digits_r    <= 1'b0;
      neg_r       <= 1'b0;
      acc_r       <= 32'd0;
      kind_r      <= rft_pkg::KIND_NONE;
    end else if (step_en) begin
      in_quotes_r <= in_quotes_nxt;
      in_parens_r <= in_parens_nxt;
      started_r   <= started_nxt;
      raw_mode_r  <= raw_mode_nxt;
      space_r     <= space_nxt;
      wpos_r      <= wpos_nxt;
      digits_r    <= digits_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      kind_r      <= kind_nxt;
    end
  end

endmodule

// ----- design/response_field_tokenizer_top.sv -----
// channel   | direction | handshake            | payload
// input     | in        | in_valid / in_stall  | in_char_in
// result    | out       | out_valid / out_stall| out_store_*, out_field_*, out_number_value
// config    | in        | cfg_we               | cfg_index, cfg_wdata
//
// one item per cycle sustained while out_stall is low; an item is taken into the
// input register, goes through the character decode and field state update, and is
// offered from the result register. rst_n is synchronous and clears the field state,
// configuration and both valid flags. out_stall holds the result register and, once
// the input register is also full, raises in_stall in the same cycle.
`include "assert_macros.svh"

module response_field_tokenizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_store_valid,
  output logic [7:0]         out_store_byte,
  output logic [7:0]         out_store_index,
  output logic [2:0]         out_field_status,
  output logic [1:0]         out_field_kind,
  output logic signed [31:0] out_number_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  rft_pkg::cfg_t     cfg;
  rft_pkg::result_t  step_res;
  rft_pkg::result_t  res_r;

  logic       pipe_valid_r;
  logic [7:0] pipe_char_r;
  logic       out_valid_r;
  logic       out_ready;
  logic       advance;
  logic       in_take;

  // handshake between the two registers
  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = pipe_valid_r && out_ready;
  assign in_stall  = pipe_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  rft_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rft_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .char_in (pipe_char_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_valid_r <= 1'b0;
    end else if (in_take) begin
      pipe_valid_r <= 1'b1;
    end else if (advance) begin
      pipe_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pipe_char_r <= in_char_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_store_valid  = res_r.store_valid;
  assign out_store_byte   = res_r.store_byte;
  assign out_store_index  = res_r.store_index;
  assign out_field_status = res_r.status;
  assign out_field_kind   = res_r.kind;
  assign out_number_value = res_r.value;

  // a write only ever comes from a text capture
  `RFT_ASSERT_IMP(a_store_is_text, clk, rst_n, out_valid && out_store_valid, out_field_kind == rft_pkg::KIND_TEXT)
  // a number only shows for an integer field
  `RFT_ASSERT_IMP(a_value_is_int, clk, rst_n, out_valid && out_number_value != 32'sd0, out_field_kind == rft_pkg::KIND_INT)
  // an error never writes to the buffer
  `RFT_ASSERT_IMP(a_error_no_store, clk, rst_n, out_valid && out_field_status == rft_pkg::ST_ERROR, !out_store_valid)
  // an accepted item lands in the input register
  `RFT_ASSERT_NEXT(a_item_loaded, clk, rst_n, in_valid && !in_stall, pipe_valid_r)

endmodule

// ----- verif/response_field_tokenizer_top_test.sv -----
module response_field_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 125;
  localparam int HOLD_CYCLES    = 47;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_in  = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic               out_store_valid;
  logic [7:0]         out_store_byte;
  logic [7:0]         out_store_index;
  logic [2:0]         out_field_status;
  logic [1:0]         out_field_kind;
  logic signed [31:0] out_number_value;
  logic               cfg_we      = 1'b0;
  logic [1:0]         cfg_index   = CFG_BUFFER_PRESENT;
  logic [7:0]         cfg_wdata   = '0;

  response_field_tokenizer_top dut (.*);

  // register mirror
  logic       m_present = 1'b0;
  logic       m_text    = 1'b0;
  logic [7:0] m_space   = '0;

  // field state of the tokenizer model
  logic        tk_quotes  = 1'b0;
  logic        tk_parens  = 1'b0;
  logic        tk_started = 1'b0;
  logic        tk_raw     = 1'b0;
  logic        tk_digits  = 1'b0;
  logic        tk_neg     = 1'b0;
  logic [7:0]  tk_space_left = '0;
  logic [7:0]  tk_wpos    = '0;
  logic [31:0] tk_acc     = '0;
  kind_t       tk_kind    = KIND_NONE;

  logic [7:0] pending_chars[$];
  result_t    expected_fields[$];
  int         n_queued     = 0;
  int         n_in         = 0;
  int         n_checked    = 0;
  int         mismatches   = 0;
  int         idle_cycles  = 0;
  int         hold_left    = 0;
  int         next_hold_at = 300;
  bit         calm         = 1'b0;
  bit         in_took      = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // tokenizer model
  function automatic void clear_field_state();
    tk_quotes     = 1'b0;
    tk_parens     = 1'b0;
    tk_started    = 1'b0;
    tk_raw        = 1'b0;
    tk_digits     = 1'b0;
    tk_neg        = 1'b0;
    tk_space_left = '0;
    tk_wpos       = '0;
    tk_acc        = '0;
    tk_kind       = KIND_NONE;
  endfunction

  function automatic void open_capture();
    tk_space_left = m_present ? m_space : 8'd0;
    tk_wpos       = 8'd0;
  endfunction

  function automatic result_t with_status(result_t r, status_t st);
    r.status = st;
    r.kind   = tk_kind;
    r.value  = (tk_kind == KIND_INT) ? (tk_neg ? (32'd0 - tk_acc) : tk_acc) : 32'd0;
    return r;
  endfunction

  function automatic result_t with_store(result_t r, logic [7:0] b);
    r.store_valid = 1'b1;
    r.store_byte  = b;
    r.store_index = tk_wpos;
    return r;
  endfunction

  function automatic result_t tokenize_char(logic [7:0] c);
    result_t r;
    logic    is_digit;
    logic    plain;
    r        = '0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    plain    = !tk_quotes && !tk_parens;
    // number keeps growing until the first non-digit
    if (tk_digits) begin
      if (is_digit) tk_acc = tk_acc * 32'd10 + {24'd0, c - CH_ZERO};
      else tk_digits = 1'b0;
    end
    if (c == CH_NUL) begin
      r = with_status(r, ST_ERROR);
      clear_field_state();
      return r;
    end
    // cr ends raw text, is dropped inside quotes, is an error elsewhere
    if (c == CH_CR) begin
      if (tk_raw) begin
        if (tk_space_left != 0) r = with_store(r, 8'd0);
        r = with_status(r, ST_CR);
        clear_field_state();
        return r;
      end
      if (!tk_quotes) begin
        r = with_status(r, ST_ERROR);
        clear_field_state();
        return r;
      end
      return with_status(r, ST_CONTINUE);
    end
    if ((c == CH_COMMA || c == CH_RPAREN) && plain) begin
      if (tk_raw && tk_space_left != 0) r = with_store(r, 8'd0);
      r = with_status(r, (c == CH_COMMA) ? ST_COMMA : ST_PAREN);
      clear_field_state();
      return r;
    end
    // closing quote terminates the capture but keeps raw mode
    if (c == CH_QUOTE) begin
      if (tk_quotes) begin
        if (tk_started && tk_space_left != 0) r = with_store(r, 8'd0);
        tk_space_left = '0;
        tk_quotes     = 1'b0;
        tk_started    = 1'b0;
      end else begin
        tk_quotes = 1'b1;
      end
      return with_status(r, ST_CONTINUE);
    end
    // first real character decides the kind of field
    if (!tk_started) begin
      tk_started = 1'b1;
      tk_digits  = 1'b0;
      if (tk_quotes) begin
        tk_kind = KIND_TEXT;
        open_capture();
      end else if (m_present && m_text) begin
        tk_raw  = 1'b1;
        tk_kind = KIND_TEXT;
        open_capture();
      end else if (is_digit || c == CH_MINUS) begin
        tk_kind   = KIND_INT;
        tk_digits = 1'b1;
        tk_neg    = (c == CH_MINUS);
        tk_acc    = is_digit ? {24'd0, c - CH_ZERO} : 32'd0;
      end else if (m_present) begin
        tk_raw  = 1'b1;
        tk_kind = KIND_TEXT;
        open_capture();
      end
    end
    // one level of brackets outside quotes
    if (c == CH_LPAREN && plain) tk_parens = 1'b1;
    else if (c == CH_RPAREN && !tk_quotes && tk_parens) tk_parens = 1'b0;
    if ((tk_quotes || tk_raw) && tk_space_left != 0) begin
      r = with_store(r, c);
      tk_wpos++;
      tk_space_left--;
    end
    return with_status(r, ST_CONTINUE);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: config mirror, item prediction, result check, watchdog
  always @(posedge clk) begin
    result_t want;
    bit      took_out;
    in_took  = rst_n && in_valid && !in_stall;
    took_out = rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUFFER_PRESENT: m_present = cfg_wdata[0];
          CFG_PRESET_TEXT:    m_text    = cfg_wdata[0];
          CFG_BUFFER_SPACE:   m_space   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_took) begin
        expected_fields.push_back(tokenize_char(in_char_in));
        n_in++;
      end
      if (took_out) begin
        n_checked++;
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, out_field_status);
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          check_field("store_valid", want.store_valid, out_store_valid);
          check_field("store_byte", want.store_byte, out_store_byte);
          check_field("store_index", want.store_index, out_store_index);
          check_field("field_status", want.status, out_field_status);
          check_field("field_kind", want.kind, out_field_kind);
          check_field("number_value", want.value, out_number_value);
        end
      end
      if (in_took || took_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // driver: offer the next pending item, hold it while stalled
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
        in_valid   <= 1'b1;
        in_char_in <= pending_chars.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off to fill the pipe
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (n_in >= next_hold_at) begin
      out_stall    <= 1'b1;
      hold_left    = HOLD_CYCLES;
      next_hold_at += 500;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  task automatic queue_char(logic [7:0] c);
    pending_chars.push_back(c);
    n_queued++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(CH_ZERO, CH_NINE));
  endfunction

  function automatic logic [7:0] text_char(bit quoted);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = rand_digit();
      1: c = quoted ? CH_COMMA : CH_LPAREN;
      2: c = quoted ? CH_CR : "_";
      3: c = quoted ? CH_RPAREN : " ";
      default: c = 8'($urandom_range("a", "z"));
    endcase
    return c;
  endfunction

  // one field of a response, mostly well formed, then its delimiter
  task automatic queue_field();
    int shape;
    int len;
    shape = $urandom_range(0, 19);
    if (shape < 6) begin
      // integer, now and then long enough to wrap
      if ($urandom_range(0, 2) == 0) queue_char(CH_MINUS);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
      repeat (len) queue_char(rand_digit());
    end else if (shape < 10) begin
      // quoted text, rarely longer than any capture space
      queue_char(CH_QUOTE);
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 8);
      repeat (len) queue_char(text_char(1'b1));
      queue_char(CH_QUOTE);
    end else if (shape < 13) begin
      // raw text, sometimes with a quoted tail
      len = $urandom_range(1, 8);
      repeat (len) queue_char(text_char(1'b0));
      if ($urandom_range(0, 3) == 0) begin
        queue_char(CH_QUOTE);
        repeat ($urandom_range(0, 3)) queue_char(text_char(1'b1));
        queue_char(CH_QUOTE);
      end
    end else if (shape < 15) begin
      // bracketed list
      queue_char(CH_LPAREN);
      repeat ($urandom_range(1, 3)) begin
        queue_char(rand_digit());
        queue_char(CH_COMMA);
      end
      queue_char(text_char(1'b0));
      queue_char(CH_RPAREN);
    end else if (shape < 18) begin
      // noise over the whole byte range
      repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 9))
      0: queue_char(CH_RPAREN);
      1: queue_char(CH_CR);
      2: queue_char(CH_NUL);
      default: queue_char(CH_COMMA);
    endcase
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_setting(logic present, logic preset, logic [7:0] space);
    write_reg(CFG_BUFFER_PRESENT, {7'd0, present});
    write_reg(CFG_PRESET_TEXT, {7'd0, preset});
    write_reg(CFG_BUFFER_SPACE, space);
  endtask

  // all results in, then a wait for the pipe to empty
  task automatic wait_idle();
    while (n_checked < n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int         first;
    logic       present;
    logic       preset;
    logic [7:0] space;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // integer with no capture buffer
    queue_text("-12");
    queue_char(CH_COMMA);
    wait_idle();

    apply_setting(1'b1, 1'b0, 8'd4);
    // quoted text with cr and bracket inside, overflowing a small capture
    queue_char(CH_QUOTE);
    queue_text("ab");
    queue_char(CH_CR);
    queue_char(CH_LPAREN);
    queue_text("cd");
    queue_char(CH_QUOTE);
    queue_char(CH_COMMA);
    // lone minus closed by a bracket
    queue_char(CH_MINUS);
    queue_char(CH_RPAREN);
    // raw text with a quoted part, ended by cr
    queue_text("x");
    queue_char(CH_QUOTE);
    queue_text("y");
    queue_char(CH_QUOTE);
    queue_char(CH_CR);
    // stray cr, nul, top-bit bytes
    queue_char(CH_CR);
    queue_char(CH_NUL);
    queue_char(8'hFF);
    queue_char(8'h80);
    queue_char(CH_COMMA);
    wait_idle();

    // random phases over a range of settings
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin present = 1'b1; preset = 1'b0; space = 8'd8;   end
        1: begin present = 1'b1; preset = 1'b1; space = 8'd3;   end
        2: begin present = 1'b0; preset = 1'b1; space = 8'd255; end
        3: begin present = 1'b1; preset = 1'b0; space = 8'd255; end
        4: begin present = 1'b1; preset = 1'b1; space = 8'd1;   end
        5: begin present = 1'b1; preset = 1'b0; space = 8'd0;   end
        6: begin present = 1'b0; preset = 1'b0; space = 8'd17;  end
        default: begin
          present = 1'($urandom_range(0, 1));
          preset  = 1'($urandom_range(0, 1));
          space   = 8'($urandom_range(0, 255));
        end
      endcase
      calm = (p == 3);
      apply_setting(present, preset, space);
      first = n_queued;
      while (n_queued - first < PHASE_ITEMS) queue_field();
      wait_idle();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (expected_fields.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_fields.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
